>>> rtl/core/mtvm_pkg.sv
// Shared types and constants for the transposed matrix-vector accumulator.
package mtvm_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 40;
    localparam int COL_W  = 6;
    localparam int SIZE_W = 7;

    typedef struct packed {
        logic signed [ELEM_W-1:0] matrix_element;
        logic signed [ELEM_W-1:0] vector_element;
    } mtvm_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] column_sum;
        logic [COL_W-1:0]        column_index;
        logic                    last_element;
    } mtvm_out_t;

    // One product travelling down the chain towards its column's cell
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic [COL_W-1:0]         col;
        logic                     first;
        logic                     emit;
        logic                     last;
        logic signed [ACC_W-1:0]  sum;
    } mtvm_token_t;

endpackage

>>> rtl/core/mtvm_feed.sv
// Entry stage: row/column counters, held vector value and the multiplier.
module mtvm_feed
    import mtvm_pkg::*;
#(
    parameter int MAX_SIZE = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                accept,
    input  mtvm_in_t            req,
    input  logic [SIZE_W-1:0]   size,
    output logic                tok_valid,
    output mtvm_token_t         tok
);

    localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);

    logic [COL_W-1:0]         row_reg, row_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic signed [ELEM_W-1:0] held_reg, held_next;
    logic                     tok_valid_reg;
    mtvm_token_t              tok_reg;

    logic [SIZE_W-1:0]        size_eff;
    logic [SIZE_W-1:0]        n_m1;
    logic                     last_row;
    logic                     last_col;
    logic signed [PROD_W-1:0] product;

    always_comb
    begin
        if (size == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (size > MAX_N)
        begin
            size_eff = MAX_N;
        end
        else
        begin
            size_eff = size;
        end
        n_m1     = size_eff - SIZE_W'(1);
        last_row = {1'b0, row_reg} >= n_m1;
        last_col = {1'b0, col_reg} >= n_m1;

        // latch the vector element on column 0 only
        held_next = (col_reg == '0) ? req.vector_element : held_reg;
        product   = held_next * req.matrix_element;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + COL_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            held_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                held_reg <= held_next;
            end
            if (adv)
            begin
                tok_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg.product <= product;
            tok_reg.col     <= col_reg;
            tok_reg.first   <= (row_reg == '0);
            tok_reg.emit    <= last_row;
            tok_reg.last    <= last_col;
            tok_reg.sum     <= '0;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

>>> rtl/core/mtvm_cell.sv
// One chain cell: holds the accumulator of a single column and passes requests on.
module mtvm_cell
    import mtvm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         valid_in,
    input  mtvm_token_t  tok_in,
    output logic         valid_out,
    output mtvm_token_t  tok_out
);

    localparam logic [COL_W-1:0] MY_COL = COL_W'(IDX);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] prod_ext;
    logic                    valid_reg;
    mtvm_token_t             tok_reg, tok_next;
    logic                    hit;

    always_comb
    begin
        hit      = valid_in && (tok_in.col == MY_COL);
        prod_ext = ACC_W'(tok_in.product);
        // row 0 overwrites, later rows add
        acc_next = tok_in.first ? prod_ext : acc_reg + prod_ext;
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.sum = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
            if (hit)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

>>> rtl/core/matrix_transpose_vector_mac.sv
// Top level: streaming transposed-matrix times vector accumulator built as a cell chain.
//
//  channel  | signals                                   | accepted when
//  ---------+-------------------------------------------+------------------------------
//  matrix   | matrix_valid, matrix_ready, matrix_data   | matrix_valid && matrix_ready
//  result   | result_valid, result_ready, result_data   | result_valid && result_ready
//  config   | cfg_wr_en, cfg_wr_data                    | cfg_wr_en
//
// One request per cycle is taken while the chain is not held; each passes the multiplier
// stage, then MAX_SIZE cells in turn; later requests follow before earlier ones are out.
// The cell of column c updates its accumulator as the request for column c passes it.
// A result held on the output with result_ready low freezes the whole chain and
// matrix_ready; requests that give no result leave the chain silently.
// Reset clears counters, held vector value and valid bits; size_reg resets to 64.
module matrix_transpose_vector_mac
    import mtvm_pkg::*;
#(
    parameter int MAX_SIZE = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               matrix_valid,
    output logic               matrix_ready,
    input  mtvm_in_t           matrix_data,
    output logic               result_valid,
    input  logic               result_ready,
    output mtvm_out_t          result_data,
    input  logic               cfg_wr_en,
    input  logic [SIZE_W-1:0]  cfg_wr_data
);

    logic [SIZE_W-1:0] size_reg;
    logic              adv;
    logic              accept;
    logic              chain_valid [MAX_SIZE+1];
    mtvm_token_t       chain_tok   [MAX_SIZE+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(64);
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    // hold the chain only while a real result waits at the tail
    assign adv          = !result_valid || result_ready;
    assign matrix_ready = adv;
    assign accept       = matrix_valid && adv;

    mtvm_feed #(
        .MAX_SIZE (MAX_SIZE)
    ) u_feed (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .req       (matrix_data),
        .size      (size_reg),
        .tok_valid (chain_valid[0]),
        .tok       (chain_tok[0])
    );

    for (genvar i = 0; i < MAX_SIZE; i++)
    begin : g_cell
        mtvm_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (chain_valid[i]),
            .tok_in    (chain_tok[i]),
            .valid_out (chain_valid[i+1]),
            .tok_out   (chain_tok[i+1])
        );
    end

    assign result_valid             = chain_valid[MAX_SIZE] && chain_tok[MAX_SIZE].emit;
    assign result_data.column_sum   = chain_tok[MAX_SIZE].sum;
    assign result_data.column_index = chain_tok[MAX_SIZE].col;
    assign result_data.last_element = chain_tok[MAX_SIZE].last;

endmodule

>>> rtl/core/mtvm_checker.sv
// Port-level checker for the accumulator top level, attached by bind.
module mtvm_checker
    import mtvm_pkg::*;
#(
    parameter int MAX_SIZE = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               matrix_valid,
    input  logic               matrix_ready,
    input  mtvm_in_t           matrix_data,
    input  logic               result_valid,
    input  logic               result_ready,
    input  mtvm_out_t          result_data,
    input  logic               cfg_wr_en,
    input  logic [SIZE_W-1:0]  cfg_wr_data
);

    localparam logic [COL_W-1:0] TOP_COL = COL_W'(MAX_SIZE - 1);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed or vanished");

    // take requests whenever the output side is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_ready == (!result_valid || result_ready))
        else $error("matrix_ready does not follow the output stage");

    // the highest column is always the end of a vector
    a_top_col_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.column_index == TOP_COL |-> result_data.last_element)
        else $error("highest column not flagged last");

endmodule

bind matrix_transpose_vector_mac mtvm_checker #(.MAX_SIZE(MAX_SIZE)) u_mtvm_checker (.*);

>>> test/tb.sv
// Self-checking bench for the transposed matrix-vector accumulator, with a request-level predictor.
`timescale 1ns / 1ps

module tb;
    import mtvm_pkg::*;

    localparam int MAX_SIZE    = 64;
    localparam int DRAIN_WAIT  = MAX_SIZE + 1 + 15;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              matrix_valid;
    logic              matrix_ready;
    mtvm_in_t          matrix_data;
    logic              result_valid;
    logic              result_ready;
    mtvm_out_t         result_data;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    // predictor state
    logic signed [ACC_W-1:0]  col_acc [MAX_SIZE];
    logic [COL_W-1:0]         row_cnt;
    logic [COL_W-1:0]         col_cnt;
    logic signed [ELEM_W-1:0] held_vec;
    logic [SIZE_W-1:0]        size_reg;

    mtvm_in_t  pending [$];
    mtvm_out_t sums_due [$];

    int   reqs_queued;
    int   reqs_taken;
    int   errors;
    int   cycles    = 0;
    int   hold_left = 0;
    logic hold_used = 1'b0;
    logic hold_start;
    logic no_idle;
    logic req_taken;

    matrix_transpose_vector_mac #(
        .MAX_SIZE(MAX_SIZE)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .matrix_data  (matrix_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Multiply by the held vector value, store or add into the column, and emit on the last row.
    task automatic accumulate_request(input mtvm_in_t req);
        int                       n;
        logic                     last_row;
        logic                     last_col;
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        mtvm_out_t                sum_out;
        n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
        last_row = int'(row_cnt) >= n - 1;
        last_col = int'(col_cnt) >= n - 1;
        if (col_cnt == 0)
            held_vec = req.vector_element;
        prod = req.matrix_element * held_vec;
        if (row_cnt == 0)
            acc = ACC_W'(prod);
        else
            acc = col_acc[col_cnt] + ACC_W'(prod);
        col_acc[col_cnt] = acc;
        if (last_row)
        begin
            sum_out.column_sum   = acc;
            sum_out.column_index = col_cnt;
            sum_out.last_element = last_col;
            sums_due.push_back(sum_out);
        end
        if (last_col)
        begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic queue_req(input logic signed [ELEM_W-1:0] m_elem,
                             input logic signed [ELEM_W-1:0] v_elem);
        mtvm_in_t req;
        req.matrix_element = m_elem;
        req.vector_element = v_elem;
        pending.push_back(req);
        reqs_queued++;
    endtask

    task automatic queue_reqs(input int count);
        repeat (count) queue_req(rand_elem(), rand_elem());
    endtask

    // Hold until every request is in and every sum is out, then let the chain empty.
    task automatic settle();
        while (reqs_taken != reqs_queued || sums_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg = value;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!matrix_valid || req_taken))
        begin
            if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 25))
            begin
                matrix_data  <= pending.pop_front();
                matrix_valid <= 1'b1;
            end
            else
            begin
                matrix_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (hold_start && !hold_used)
        begin
            hold_used    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        mtvm_out_t due;
        req_taken <= matrix_valid && matrix_ready;
        if (rst_n)
        begin
            if (matrix_valid && matrix_ready)
            begin
                accumulate_request(matrix_data);
                reqs_taken++;
            end
            if (result_valid && result_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("unexpected result: column_index %0d column_sum %0d",
                           result_data.column_index, result_data.column_sum);
                    errors++;
                end
                else
                begin
                    due = sums_due.pop_front();
                    if (result_data.column_sum !== due.column_sum)
                    begin
                        $error("column_sum: expected %0d, actual %0d",
                               due.column_sum, result_data.column_sum);
                        errors++;
                    end
                    if (result_data.column_index !== due.column_index)
                    begin
                        $error("column_index: expected %0d, actual %0d",
                               due.column_index, result_data.column_index);
                        errors++;
                    end
                    if (result_data.last_element !== due.last_element)
                    begin
                        $error("last_element: expected %0d, actual %0d",
                               due.last_element, result_data.last_element);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** matrix_transpose_vector_mac: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int n;
        int v;
        int r;
        int m;
        int c;
        int cnt;
        int mode;
        int phase;
        int rand_items;

        rst_n        = 1'b0;
        matrix_valid = 1'b0;
        matrix_data  = '0;
        result_ready = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_taken    = 1'b0;
        hold_start   = 1'b0;
        no_idle      = 1'b0;
        reqs_queued  = 0;
        reqs_taken   = 0;
        errors       = 0;
        size_reg     = SIZE_W'(MAX_SIZE);
        row_cnt      = '0;
        col_cnt      = '0;
        held_vec     = '0;
        for (int i = 0; i < MAX_SIZE; i++)
            col_acc[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // size 0 acts as 1: every request is a whole matrix
        set_size('0);
        queue_req(16'sh7fff, 16'sh7fff);
        queue_req(16'sh8000, 16'sh8000);
        queue_req(16'sh8000, 16'sh7fff);
        settle();

        // vector element away from column 0 must be dropped
        set_size(SIZE_W'(2));
        queue_req(16'sh8000, 16'sh8000);
        queue_req(16'sh8000, 16'sh1234);
        queue_req(16'sh7fff, 16'sh8000);
        queue_req(16'sh0001, 16'sh7fff);
        settle();

        // shrink mid-row: column 2 then lies past the new last column
        set_size(SIZE_W'(3));
        queue_reqs(5);
        settle();
        set_size(SIZE_W'(2));
        queue_reqs(1);
        settle();

        // grow during row 0
        queue_reqs(1);
        settle();
        set_size(SIZE_W'(3));
        queue_reqs(8);
        settle();

        // receiver holds off while the sender keeps offering
        set_size(SIZE_W'(1));
        hold_start = 1'b1;
        queue_reqs(200);
        settle();

        rand_items = 200;
        phase      = 0;
        while (rand_items < 1050)
        begin
            phase++;
            no_idle = (phase <= 4);
            r = $urandom_range(19);
            if (r == 0)
                v = 0;
            else if (r <= 12)
                v = $urandom_range(1, 6);
            else if (r <= 17)
                v = $urandom_range(7, 12);
            else
                v = $urandom_range(13, 20);
            n = (v == 0) ? 1 : v;
            mode = (n < 2) ? 2 : $urandom_range(5);
            set_size(SIZE_W'(v));
            case (mode)
                0:
                begin
                    // stop on a row boundary and shrink
                    r = $urandom_range(1, n - 1);
                    queue_reqs(r * n);
                    settle();
                    m = $urandom_range(1, n - 1);
                    set_size(SIZE_W'(m));
                    cnt = ((r >= m - 1) ? 1 : m - r) * m;
                    queue_reqs(cnt);
                    settle();
                    rand_items += r * n + cnt;
                end
                1:
                begin
                    // stop part way through row 0 and grow
                    c = $urandom_range(1, n - 1);
                    queue_reqs(c);
                    settle();
                    m = n + $urandom_range(1, 4);
                    set_size(SIZE_W'(m));
                    cnt = (m - c) + (m - 1) * m;
                    queue_reqs(cnt);
                    settle();
                    rand_items += c + cnt;
                end
                default:
                begin
                    cnt = $urandom_range(1, 3) * n * n;
                    queue_reqs(cnt);
                    settle();
                    rand_items += cnt;
                end
            endcase
        end
        no_idle = 1'b0;

        // over-range size acts as the largest: one full row, then shrink to finish
        set_size('1);
        queue_reqs(MAX_SIZE);
        settle();
        m = $urandom_range(1, 3);
        set_size(SIZE_W'(m));
        queue_reqs(((m <= 2) ? 1 : m - 1) * m);
        settle();

        // largest size, four full rows of the largest product, then shrink to close the matrix
        set_size(SIZE_W'(MAX_SIZE));
        repeat (4 * MAX_SIZE) queue_req(16'sh8000, 16'sh8000);
        settle();
        set_size(SIZE_W'(2));
        repeat (2) queue_req(16'sh8000, 16'sh8000);
        settle();

        if (errors == 0)
            $display("** matrix_transpose_vector_mac: PASSED **");
        else
            $display("** matrix_transpose_vector_mac: FAILED **");
        $finish;
    end

endmodule
